// ===== design/dtp_pkg.sv =====
// dtp_pkg: shared types, widths, register indexes and reset values
// for the depth-to-point back-projection block
// no dependencies
package dtp_pkg;

    // fixed field widths
    localparam int DIM_W      = 13;   // frame size registers
    localparam int FOCAL_W    = 20;   // focal length registers
    localparam int DEPTH_W    = 16;   // depth pixel
    localparam int COORD_W    = 32;   // x and y results
    localparam int MAG_W      = DIM_W + 1;             // |2u - W - 1|
    localparam int PROD_W     = MAG_W + DEPTH_W;       // |offset| * depth
    localparam int NUM_W      = PROD_W + 3;            // times eight
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FOCAL_W;
    localparam int OUT_DATA_W = 2 * COORD_W + DEPTH_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 2'd3;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
    localparam logic [FOCAL_W-1:0] RST_FOCAL        = 20'd5460;

    // default parameter values
    localparam int DECIMATION_DEF = 4;
    localparam int MAX_DIM_DEF    = 4096;
    localparam int QUEUE_DEPTH    = 4;

    // one kept pixel, classified and ready for projection
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               x_neg;
        logic [MAG_W-1:0]   x_mag;
        logic               y_neg;
        logic [MAG_W-1:0]   y_mag;
        logic               last;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== design/dtp_front.sv =====
// dtp_front: raster position counters, decimation grid check and
// pixel offset from the optical centre; pushes kept pixels to the queue
// depends on dtp_pkg
module dtp_front #(
    parameter int DECIMATION = dtp_pkg::DECIMATION_DEF,
    parameter int MAX_DIM    = dtp_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dtp_pkg::DEPTH_W-1:0] i_depth,
    input  logic                        i_frame_start,
    input  logic [dtp_pkg::DIM_W-1:0]   i_eff_w,
    input  logic [dtp_pkg::DIM_W-1:0]   i_eff_h,
    input  dtp_pkg::t_qstat             i_qstat,
    output logic                        o_push,
    output dtp_pkg::t_item              o_item
);

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int PH_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int SUM_W = dtp_pkg::DIM_W + 2;
    localparam int OFF_W = dtp_pkg::DIM_W + 2;

    logic [POS_W-1:0] r_col, n_col, r_row, n_row;
    logic [PH_W-1:0]  r_col_ph, n_col_ph, r_row_ph, n_row_ph;

    logic [POS_W-1:0] w_col, w_row;
    logic [PH_W-1:0]  w_col_ph, w_row_ph;
    logic [POS_W:0]   w_col_inc, w_row_inc;
    logic             w_accept, w_keep, w_last;
    logic [OFF_W-1:0] w_off_x, w_off_y, w_neg_x, w_neg_y;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;

    // position of this pixel, frame start restarts the raster
    assign w_col    = i_frame_start ? '0 : r_col;
    assign w_row    = i_frame_start ? '0 : r_row;
    assign w_col_ph = i_frame_start ? '0 : r_col_ph;
    assign w_row_ph = i_frame_start ? '0 : r_row_ph;

    // on the grid and inside the whole decimated area
    always_comb begin
        w_keep = (w_col_ph == '0) && (w_row_ph == '0)
              && (SUM_W'(w_col) + SUM_W'(DECIMATION) <= SUM_W'(i_eff_w))
              && (SUM_W'(w_row) + SUM_W'(DECIMATION) <= SUM_W'(i_eff_h));
        w_last = (SUM_W'(w_col) + SUM_W'(2 * DECIMATION) > SUM_W'(i_eff_w))
              && (SUM_W'(w_row) + SUM_W'(2 * DECIMATION) > SUM_W'(i_eff_h));
    end

    // offset 2u - W - 1 as sign and magnitude
    always_comb begin
        w_off_x = OFF_W'({w_col, 1'b0}) - OFF_W'(i_eff_w) - OFF_W'(1);
        w_off_y = OFF_W'({w_row, 1'b0}) - OFF_W'(i_eff_h) - OFF_W'(1);
        w_neg_x = '0 - w_off_x;
        w_neg_y = '0 - w_off_y;
        o_item.depth = i_depth;
        o_item.x_neg = w_off_x[OFF_W-1];
        o_item.x_mag = w_off_x[OFF_W-1] ? w_neg_x[dtp_pkg::MAG_W-1:0]
                                        : w_off_x[dtp_pkg::MAG_W-1:0];
        o_item.y_neg = w_off_y[OFF_W-1];
        o_item.y_mag = w_off_y[OFF_W-1] ? w_neg_y[dtp_pkg::MAG_W-1:0]
                                        : w_off_y[dtp_pkg::MAG_W-1:0];
        o_item.last  = w_last;
    end

    assign o_push = w_accept && w_keep;

    // raster advance with wrap at frame size
    always_comb begin
        w_col_inc = {1'b0, w_col} + (POS_W+1)'(1);
        w_row_inc = {1'b0, w_row} + (POS_W+1)'(1);
        n_col     = r_col;
        n_row     = r_row;
        n_col_ph  = r_col_ph;
        n_row_ph  = r_row_ph;
        if (w_accept) begin
            if (SUM_W'(w_col_inc) >= SUM_W'(i_eff_w)) begin
                n_col    = '0;
                n_col_ph = '0;
                if (SUM_W'(w_row_inc) >= SUM_W'(i_eff_h)) begin
                    n_row    = '0;
                    n_row_ph = '0;
                end else begin
                    n_row    = w_row_inc[POS_W-1:0];
                    n_row_ph = (w_row_ph == PH_W'(DECIMATION - 1)) ? '0
                                                                    : w_row_ph + PH_W'(1);
                end
            end else begin
                n_col    = w_col_inc[POS_W-1:0];
                n_col_ph = (w_col_ph == PH_W'(DECIMATION - 1)) ? '0
                                                                : w_col_ph + PH_W'(1);
                n_row    = w_row;
                n_row_ph = w_row_ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_col_ph <= n_col_ph;
            r_row_ph <= n_row_ph;
        end
    end

endmodule

// ===== design/dtp_queue.sv =====
// dtp_queue: short first-in first-out queue of kept pixels between the
// classifying front and the projecting back
// depends on dtp_pkg
module dtp_queue #(
    parameter int DEPTH = dtp_pkg::QUEUE_DEPTH   // 2 or more
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtp_pkg::t_item  i_item,
    input  logic            i_pop,
    output dtp_pkg::t_item  o_item,
    output dtp_pkg::t_qstat o_qstat
);

    localparam int AW = $clog2(DEPTH);

    dtp_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [AW:0]    r_cnt, n_cnt;
    logic           w_push, w_pop;

    assign o_qstat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_qstat.full;
    assign w_pop  = i_pop && !o_qstat.empty;
    assign o_item = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== design/dtp_div.sv =====
// dtp_div: unsigned restoring divider, one quotient bit per cycle
// no package dependency
module dtp_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_acc;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial, w_diff;
    logic             w_qbit;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_acc[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_qbit  = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // dividend shifts out as the quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= {r_acc[NUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_acc;

endmodule

// ===== design/dtp_back.sv =====
// dtp_back: takes kept pixels from the queue, multiplies offset by depth,
// divides by the focal lengths, saturates and holds the result
// depends on dtp_pkg and dtp_div
module dtp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtp_pkg::t_qstat               i_qstat,
    input  dtp_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [dtp_pkg::FOCAL_W-1:0]   i_eff_fx,
    input  logic [dtp_pkg::FOCAL_W-1:0]   i_eff_fy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dtp_pkg::OUT_DATA_W-1:0] o_data,
    output logic                          o_point_valid,
    output logic                          o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    localparam int CW = dtp_pkg::COORD_W;
    localparam int NW = dtp_pkg::NUM_W;

    logic [1:0]          r_state, n_state;
    dtp_pkg::t_item      r_item;
    logic [dtp_pkg::PROD_W-1:0] w_prod_x, w_prod_y;
    logic [NW-1:0]       w_quo_x, w_quo_y;
    logic                w_done_x, w_done_y, w_start, w_load;
    logic [CW-1:0]       w_x, w_y;

    logic                r_out_valid;
    logic [CW-1:0]       r_out_x, r_out_y;
    logic [dtp_pkg::DEPTH_W-1:0] r_out_z;
    logic                r_out_pv, r_out_last;

    // saturate a sign-magnitude quotient to signed 32 bits
    function automatic logic [CW-1:0] sat_coord(input logic neg, input logic [NW-1:0] q);
        logic [CW-1:0] res;
        if (!neg) begin
            res = (q[NW-1:CW-1] != '0) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
        end else if ((q[NW-1:CW] != '0) || (q[CW-1] && (q[CW-2:0] != '0))) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = '0 - q[CW-1:0];
        end
        return res;
    endfunction

    // offset times depth, registered by the dividers' load
    always_comb begin
        w_prod_x = dtp_pkg::PROD_W'(r_item.x_mag) * dtp_pkg::PROD_W'(r_item.depth);
        w_prod_y = dtp_pkg::PROD_W'(r_item.y_mag) * dtp_pkg::PROD_W'(r_item.depth);
    end

    assign w_start = (r_state == S_MUL);

    dtp_div #(.NUM_W(NW), .DEN_W(dtp_pkg::FOCAL_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({w_prod_x, 3'b000}),
        .i_den   (i_eff_fx),
        .o_done  (w_done_x),
        .o_quo   (w_quo_x)
    );

    dtp_div #(.NUM_W(NW), .DEN_W(dtp_pkg::FOCAL_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   ({w_prod_y, 3'b000}),
        .i_den   (i_eff_fy),
        .o_done  (w_done_y),
        .o_quo   (w_quo_y)
    );

    assign w_x = sat_coord(r_item.x_neg, w_quo_x);
    assign w_y = sat_coord(r_item.y_neg, w_quo_y);

    // sequencer: take an entry, start the dividers, hand over the result
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_done_x && w_done_y && (!r_out_valid || i_ready)) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working entry and output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (w_load) begin
            r_out_x    <= w_x;
            r_out_y    <= w_y;
            r_out_z    <= r_item.depth;
            r_out_pv   <= (r_item.depth != '0);
            r_out_last <= r_item.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_data        = {r_out_z, r_out_y, r_out_x};
    assign o_point_valid = r_out_pv;
    assign o_last        = r_out_last;

endmodule

// ===== design/depth_to_point_projection.sv =====
// depth_to_point_projection: top level, configuration registers and
// wiring of front, queue and back
// depends on dtp_pkg, dtp_front, dtp_queue, dtp_back
//
// Usage
// - s_axis carries one depth pixel per transaction (millimetres); tuser set
//   marks column 0, row 0 of a frame. Column and row are counted inside.
// - Only pixels on the decimated grid yield a point on m_axis: x, y and z in
//   tdata, point_valid in tuser, tlast on the final point of the grid.
// - Registers (frame size, focal lengths) are written through the cfg port
//   while the block is idle; sizes are clamped to 1..MAX_DIM, a focal length
//   of zero counts as one.
// - Input pixels are taken one per cycle while the four-entry point queue has
//   room. The back end handles one point at a time: it fetches the entry,
//   multiplies, runs the bit-serial division (x and y in parallel) and
//   loads the output register.
// - Reset clears raster counters, queue and output, and reloads the register
//   defaults. A stalled receiver holds the output register; the back end
//   then waits and the queue fills before s_axis_tready drops.
module depth_to_point_projection #(
    parameter int DECIMATION = dtp_pkg::DECIMATION_DEF,
    parameter int MAX_DIM    = dtp_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [dtp_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [dtp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // depth pixel stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dtp_pkg::DEPTH_W-1:0]     s_axis_tdata,   // [15:0] depth_mm
    input  logic                            s_axis_tuser,   // [0] frame_start
    // point stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dtp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] x_mm, [63:32] y_mm,
                                                            // [79:64] z_mm
    output logic                            m_axis_tuser,   // [0] point_valid
    output logic                            m_axis_tlast    // last_point
);

    localparam int CMP_W = dtp_pkg::DIM_W + 1;

    logic [dtp_pkg::DIM_W-1:0]   r_frame_width, r_frame_height;
    logic [dtp_pkg::FOCAL_W-1:0] r_focal_x, r_focal_y;
    logic [dtp_pkg::DIM_W-1:0]   w_eff_w, w_eff_h;
    logic [dtp_pkg::FOCAL_W-1:0] w_eff_fx, w_eff_fy;

    dtp_pkg::t_item  w_push_item, w_head_item;
    dtp_pkg::t_qstat w_qstat;
    logic            w_push, w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= dtp_pkg::RST_FRAME_WIDTH;
            r_frame_height <= dtp_pkg::RST_FRAME_HEIGHT;
            r_focal_x      <= dtp_pkg::RST_FOCAL;
            r_focal_y      <= dtp_pkg::RST_FOCAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dtp_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[dtp_pkg::DIM_W-1:0];
                dtp_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[dtp_pkg::DIM_W-1:0];
                dtp_pkg::REG_FOCAL_X:      r_focal_x      <= i_cfg_wdata;
                dtp_pkg::REG_FOCAL_Y:      r_focal_y      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // effective sizes and focal lengths
    always_comb begin
        if ({1'b0, r_frame_width} > CMP_W'(MAX_DIM)) begin
            w_eff_w = dtp_pkg::DIM_W'(MAX_DIM);
        end else if (r_frame_width == '0) begin
            w_eff_w = dtp_pkg::DIM_W'(1);
        end else begin
            w_eff_w = r_frame_width;
        end
        if ({1'b0, r_frame_height} > CMP_W'(MAX_DIM)) begin
            w_eff_h = dtp_pkg::DIM_W'(MAX_DIM);
        end else if (r_frame_height == '0) begin
            w_eff_h = dtp_pkg::DIM_W'(1);
        end else begin
            w_eff_h = r_frame_height;
        end
        w_eff_fx = (r_focal_x == '0) ? dtp_pkg::FOCAL_W'(1) : r_focal_x;
        w_eff_fy = (r_focal_y == '0) ? dtp_pkg::FOCAL_W'(1) : r_focal_y;
    end

    dtp_front #(.DECIMATION(DECIMATION), .MAX_DIM(MAX_DIM)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_depth       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_eff_w       (w_eff_w),
        .i_eff_h       (w_eff_h),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    dtp_queue #(.DEPTH(dtp_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_qstat (w_qstat)
    );

    dtp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qstat       (w_qstat),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .i_eff_fx      (w_eff_fx),
        .i_eff_fy      (w_eff_fy),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_point_valid (m_axis_tuser),
        .o_last        (m_axis_tlast)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("point pushed into a full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("point popped from an empty queue");

    // point_valid follows the depth, an invalid point carries zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid point with nonzero coordinates");

    a_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[dtp_pkg::OUT_DATA_W-1:
                                                          2*dtp_pkg::COORD_W] != '0)))
        else $error("point_valid does not match depth");

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
